// File: rtl/periodic_timer_table_top_defines.svh
// Assertion macros shared by the periodic timer table RTL.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef PERIODIC_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define PTT_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

`define PTT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`else

`define PTT_ASSERT_IMPL(lbl, a, c, msg)

`define PTT_ASSERT_NEXT(lbl, a, c, msg)

`endif

`endif

// File: rtl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADDED       = 3'd0;
  localparam logic [2:0] KIND_ZERO_PERIOD = 3'd1;
  localparam logic [2:0] KIND_FULL        = 3'd2;
  localparam logic [2:0] KIND_DELETED     = 3'd3;
  localparam logic [2:0] KIND_NOT_FOUND   = 3'd4;
  localparam logic [2:0] KIND_FIRED       = 3'd5;
  localparam logic [2:0] KIND_NONE_DUE    = 3'd6;

  typedef struct packed {
    logic [15:0]        id;
    logic [31:0]        period;
    logic signed [31:0] param;
    logic [31:0]        last_fire;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NBR,
    CELL_WR
  } cell_cmd_t;

  typedef enum logic [1:0] {
    CHAIN_HOLD,
    CHAIN_ROTATE,
    CHAIN_COMPACT,
    CHAIN_WRITE
  } chain_cmd_t;

endpackage

// File: rtl/ptt_req_if.sv
`timescale 1ns / 1ps

interface ptt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        timer_id;
  logic [31:0]        period_ms;
  logic signed [31:0] user_param;
  logic [31:0]        now_ms;

  modport source (output valid, op, timer_id, period_ms, user_param, now_ms,
                  input ready);
  modport sink (input valid, op, timer_id, period_ms, user_param, now_ms,
                output ready);
endinterface

// File: rtl/ptt_rsp_if.sv
`timescale 1ns / 1ps

interface ptt_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_kind;
  logic [15:0]        fired_id;
  logic signed [31:0] fired_param;
  logic               last;

  modport source (output valid, result_kind, fired_id, fired_param, last,
                  input ready);
  modport sink (input valid, result_kind, fired_id, fired_param, last,
                output ready);
endinterface

// File: rtl/ptt_cell.sv
`timescale 1ns / 1ps

module ptt_cell
  import ptt_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  entry_t    nbr,
  input  entry_t    wr,
  output entry_t    q
);

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_NBR: q <= nbr;
      CELL_WR:  q <= wr;
      default:  q <= q;
    endcase
  end

endmodule

// File: rtl/ptt_chain.sv
`timescale 1ns / 1ps

module ptt_chain
  import ptt_pkg::*;
#(
  parameter int MAX_TIMERS = 16,
  parameter int IW = 4
) (
  input  logic          clk,
  input  chain_cmd_t    cmd,
  input  logic [IW-1:0] idx,
  input  entry_t        tail,
  input  entry_t        wr,
  output entry_t        head
);

  entry_t    q   [MAX_TIMERS];
  entry_t    nbr [MAX_TIMERS];
  cell_cmd_t cc  [MAX_TIMERS];

  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
    if (i == MAX_TIMERS - 1) begin : g_tail
      assign nbr[i] = tail;
    end else begin : g_mid
      assign nbr[i] = q[i+1];
    end

    always_comb begin
      case (cmd)
        CHAIN_ROTATE:  cc[i] = CELL_NBR;
        // Entries above the removed one slide down by one place.
        CHAIN_COMPACT: cc[i] = ((IW'(i) >= idx) && (i != MAX_TIMERS - 1)) ?
                               CELL_NBR : CELL_HOLD;
        CHAIN_WRITE:   cc[i] = (IW'(i) == idx) ? CELL_WR : CELL_HOLD;
        default:       cc[i] = CELL_HOLD;
      endcase
    end

    ptt_cell u_cell (
      .clk (clk),
      .cmd (cc[i]),
      .nbr (nbr[i]),
      .wr  (wr),
      .q   (q[i])
    );
  end

  assign head = q[0];

endmodule

// File: rtl/periodic_timer_table_top.sv
`timescale 1ns / 1ps

// Ordered table of up to MAX_TIMERS periodic timers held in a ring of cells.
// An add writes the entry as it is accepted and returns its result from the
// finish state. A delete rotates the whole ring once past a compare at its
// head, closes the gap in a shift state when the id was found, and then
// returns its result. A tick rotates the ring the same way, checking one
// timer per cycle at the head unless a second fired timer must wait for a
// free output; each fired timer is held until the next one is found and
// then emitted, the final one with last set. Each item is accepted in the
// idle state. A new item is accepted only when the previous one has
// delivered its final beat into the output register.
module periodic_timer_table_top
  import ptt_pkg::*;
#(
  parameter int MAX_TIMERS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ptt_req_if.sink   req,
  ptt_rsp_if.source rsp
);

`include "periodic_timer_table_top_defines.svh"

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [IW-1:0]      step;
  logic [IW-1:0]      del_idx;
  logic               found;
  logic [1:0]         op_r;
  logic [15:0]        id_r;
  logic [31:0]        now_r;
  logic [2:0]         fin_kind;
  logic               pend_valid;
  logic [15:0]        pend_id;
  logic signed [31:0] pend_param;

  logic               o_valid;
  logic [2:0]         o_kind;
  logic [15:0]        o_id;
  logic signed [31:0] o_param;
  logic               o_last;
  logic               o_load;

  chain_cmd_t    ch_cmd;
  logic [IW-1:0] ch_idx;
  entry_t        ch_tail;
  entry_t        ch_wr;
  entry_t        head;

  logic accept, add_ok, is_tick, in_range, due, fire, match, stall, ofree;

  assign accept   = req.valid && req.ready;
  assign add_ok   = accept && (req.op == OP_ADD) && (req.period_ms != 32'd0) &&
                    (count != CW'(MAX_TIMERS));
  assign is_tick  = (op_r == OP_TICK);
  assign in_range = (CW'(step) < count);
  assign due      = ((now_r - head.last_fire) >= head.period);
  assign fire     = is_tick && in_range && due;
  assign match    = !is_tick && in_range && (head.id == id_r);
  assign ofree    = !o_valid || rsp.ready;
  // A newly fired timer pushes the held one out, which needs a free output.
  assign stall    = fire && pend_valid && !ofree;
  assign o_load   = ((state == ST_SCAN) && !stall && fire && pend_valid) ||
                    ((state == ST_FINISH) && ofree);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = o_valid;
  assign rsp.result_kind = o_kind;
  assign rsp.fired_id    = o_id;
  assign rsp.fired_param = o_param;
  assign rsp.last        = o_last;

  always_comb begin
    ch_cmd            = CHAIN_HOLD;
    ch_idx            = del_idx;
    ch_tail           = head;
    ch_tail.last_fire = fire ? now_r : head.last_fire;
    ch_wr.id          = req.timer_id;
    ch_wr.period      = req.period_ms;
    ch_wr.param       = req.user_param;
    ch_wr.last_fire   = req.now_ms;
    case (state)
      ST_IDLE: begin
        if (add_ok) begin
          ch_cmd = CHAIN_WRITE;
          ch_idx = count[IW-1:0];
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          ch_cmd = CHAIN_ROTATE;
        end
      end
      ST_SHIFT: begin
        ch_cmd = CHAIN_COMPACT;
      end
      default: ch_cmd = CHAIN_HOLD;
    endcase
  end

  ptt_chain #(
    .MAX_TIMERS (MAX_TIMERS),
    .IW         (IW)
  ) u_chain (
    .clk  (clk),
    .cmd  (ch_cmd),
    .idx  (ch_idx),
    .tail (ch_tail),
    .wr   (ch_wr),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      step       <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      if (rsp.ready && !o_load) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r  <= req.op;
            id_r  <= req.timer_id;
            now_r <= req.now_ms;
            case (req.op)
              OP_ADD: begin
                if (req.period_ms == 32'd0) begin
                  fin_kind <= KIND_ZERO_PERIOD;
                end else if (count == CW'(MAX_TIMERS)) begin
                  fin_kind <= KIND_FULL;
                end else begin
                  fin_kind <= KIND_ADDED;
                  count    <= count + 1'b1;
                end
                state <= ST_FINISH;
              end
              OP_DELETE, OP_TICK: begin
                step       <= '0;
                found      <= 1'b0;
                pend_valid <= 1'b0;
                state      <= ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (fire) begin
              if (pend_valid) begin
                o_valid <= 1'b1;
                o_kind  <= KIND_FIRED;
                o_id    <= pend_id;
                o_param <= pend_param;
                o_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= head.id;
              pend_param <= head.param;
            end
            if (match && !found) begin
              found   <= 1'b1;
              del_idx <= step;
            end
            if (step == IW'(MAX_TIMERS - 1)) begin
              step <= '0;
              if (!is_tick && (found || match)) begin
                state <= ST_SHIFT;
              end else begin
                fin_kind <= KIND_NOT_FOUND;
                state    <= ST_FINISH;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_SHIFT: begin
          count    <= count - 1'b1;
          fin_kind <= KIND_DELETED;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (ofree) begin
            o_valid <= 1'b1;
            o_last  <= 1'b1;
            if (is_tick && pend_valid) begin
              o_kind  <= KIND_FIRED;
              o_id    <= pend_id;
              o_param <= pend_param;
            end else begin
              o_kind  <= is_tick ? KIND_NONE_DUE : fin_kind;
              o_id    <= '0;
              o_param <= '0;
            end
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PTT_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(MAX_TIMERS), "timer count overflow")
  `PTT_ASSERT_IMPL(a_idle_no_pending, state == ST_IDLE, !pend_valid, "held fire left over")
  `PTT_ASSERT_NEXT(a_stall_holds, (state == ST_SCAN) && stall,
                   (state == ST_SCAN) && (step == $past(step)), "scan moved on stall")
  `PTT_ASSERT_NEXT(a_add_grows, add_ok, count == $past(count) + 1'b1,
                   "add did not grow table")

endmodule
